// ===== src/srbp_pkg.sv =====
package srbp_pkg;

	localparam int R_W         = 10;
	localparam int M_W         = 9;
	localparam int OP_W        = 9;
	localparam int PIX_W       = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DAT_W   = 10;
	localparam int F_BITS      = 8;
	localparam int D2_W        = 19;
	localparam int RQ_W        = 18;
	localparam int DEN_W       = 18;
	localparam int NUM_W       = 26;
	localparam int SQ_STAGES   = 6;
	localparam int SQ_PER_STG  = 3;
	localparam int SQ_REM_W    = 21;
	localparam int SQ_RAD_W    = 36;

	localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_RADIUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HALF   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPACITY_LEVEL = 2'd2;

	localparam logic [OP_W-1:0] OP_FULL   = 9'd256;
	localparam logic [7:0]      ALPHA_MAX = 8'hFF;

	typedef struct packed {
		logic [R_W-1:0]  radius;
		logic [M_W-1:0]  half;
		logic [OP_W-1:0] op;
	} srbp_cfg_t;

	typedef struct packed {
		logic             vres;
		logic             fix;
		logic [7:0]       afix;
		logic [RQ_W-1:0]  full;
		logic [DEN_W-1:0] den;
	} srbp_ctl_t;

endpackage

// ===== src/srbp_if.sv =====
interface srbp_pix_if;
	import srbp_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface srbp_res_if;
	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [7:0] red;
	logic [7:0] alpha;
	modport source (output valid, valid_res, red, alpha, input ready);
	modport sink   (input valid, valid_res, red, alpha, output ready);
endinterface

interface srbp_cfg_if;
	import srbp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/srbp_cfg_regs.sv =====
module srbp_cfg_regs
	import srbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output srbp_cfg_t            cfg
);

	logic [R_W-1:0]  radius_q;
	logic [M_W-1:0]  half_q;
	logic [OP_W-1:0] op_q;

	assign wr_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			half_q   <= '0;
			op_q     <= '0;
		end else if (wr_valid) begin
			unique case (wr_index)
				CFG_BRUSH_RADIUS:  radius_q <= wr_data[R_W-1:0];
				CFG_CANVAS_HALF:   half_q   <= wr_data[M_W-1:0];
				CFG_OPACITY_LEVEL: op_q     <= wr_data[OP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.radius = radius_q;
	assign cfg.half   = half_q;
	// opacity above full scale acts as full scale
	assign cfg.op     = (op_q > OP_FULL) ? OP_FULL : op_q;

endmodule

// ===== src/srbp_front.sv =====
module srbp_front
	import srbp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  srbp_cfg_t        cfg,
	input  logic             up_valid,
	output logic             up_ready,
	input  logic [PIX_W-1:0] pixel_x,
	input  logic [PIX_W-1:0] pixel_y,
	output logic             dn_valid,
	input  logic             dn_ready,
	output srbp_ctl_t        dn_ctl,
	output logic [D2_W-1:0]  dn_d2
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic            vres_s1, inside_s1;
	logic [8:0]      adx_s1, ady_s1;
	logic            vres_s2, inside_s2;
	logic [17:0]     sqx_s2, sqy_s2, core_s2;
	logic [19:0]     rr_s2;
	logic [DEN_W-1:0] den_s2;
	logic            vres_s3, inside_s3;
	logic [D2_W-1:0] d2_s3;
	logic [35:0]     core2_s3;
	logic [19:0]     rr_s3;
	logic [DEN_W-1:0] den_s3;
	srbp_ctl_t       ctl_s4;
	logic [D2_W-1:0] d2_s4;

	logic            vres_c, inside_c;
	logic [8:0]      adx_c, ady_c;
	logic            rim_c, core_c;
	srbp_ctl_t       ctl_c;

	assign en4      = !v_s4 || dn_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	always_comb begin
		logic [PIX_W-1:0] two_m;
		logic signed [11:0] dx, dy, rs, ax, ay;
		two_m    = {cfg.half, 1'b0};
		vres_c   = (cfg.radius != '0) && (cfg.half != '0) &&
			(pixel_x < two_m) && (pixel_y < two_m);
		dx       = $signed({2'b00, pixel_x}) - $signed({3'b000, cfg.half});
		dy       = $signed({2'b00, pixel_y}) - $signed({3'b000, cfg.half});
		rs       = $signed({2'b00, cfg.radius});
		inside_c = (dx >= -rs) && (dx < rs) && (dy >= -rs) && (dy < rs);
		ax       = dx[11] ? -dx : dx;
		ay       = dy[11] ? -dy : dy;
		// inside the canvas an offset is at most M, so nine bits hold it
		adx_c    = ax[8:0];
		ady_c    = ay[8:0];
	end

	always_comb begin
		rim_c       = {1'b0, d2_s3} > rr_s3;
		core_c      = {1'b0, d2_s3, 16'b0} <= core2_s3;
		ctl_c.vres  = vres_s3;
		ctl_c.fix   = !vres_s3 || !inside_s3 || rim_c || core_c;
		ctl_c.afix  = (vres_s3 && inside_s3 && !rim_c && core_c) ? ALPHA_MAX : 8'd0;
		ctl_c.full  = {cfg.radius, {F_BITS{1'b0}}};
		ctl_c.den   = den_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			vres_s1   <= vres_c;
			inside_s1 <= inside_c;
			adx_s1    <= adx_c;
			ady_s1    <= ady_c;
		end
		if (en2) begin
			vres_s2   <= vres_s1;
			inside_s2 <= inside_s1;
			sqx_s2    <= {9'b0, adx_s1} * {9'b0, adx_s1};
			sqy_s2    <= {9'b0, ady_s1} * {9'b0, ady_s1};
			rr_s2     <= {10'b0, cfg.radius} * {10'b0, cfg.radius};
			core_s2   <= {8'b0, cfg.radius} * {9'b0, cfg.op};
			den_s2    <= {8'b0, cfg.radius} * {9'b0, OP_FULL - cfg.op};
		end
		if (en3) begin
			vres_s3   <= vres_s2;
			inside_s3 <= inside_s2;
			d2_s3     <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			core2_s3  <= {18'b0, core_s2} * {18'b0, core_s2};
			rr_s3     <= rr_s2;
			den_s3    <= den_s2;
		end
		if (en4) begin
			ctl_s4 <= ctl_c;
			d2_s4  <= d2_s3;
		end
	end

	assign dn_valid = v_s4;
	assign dn_ctl   = ctl_s4;
	assign dn_d2    = d2_s4;

endmodule

// ===== src/srbp_sqrt.sv =====
module srbp_sqrt
	import srbp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  srbp_ctl_t       up_ctl,
	input  logic [D2_W-1:0] up_d2,
	output logic            dn_valid,
	input  logic            dn_ready,
	output srbp_ctl_t       dn_ctl,
	output logic [RQ_W-1:0] dn_rq
);

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [RQ_W-1:0]     root;
		logic [SQ_RAD_W-1:0] rad;
	} sq_t;

	// three root bits per stage, digit by digit
	function automatic sq_t sq_step(sq_t s);
		sq_t r;
		logic [SQ_REM_W-1:0] rem2, trial;
		r = s;
		for (int k = 0; k < SQ_PER_STG; k++) begin
			rem2  = {r.rem[SQ_REM_W-3:0], r.rad[SQ_RAD_W-1 -: 2]};
			trial = {1'b0, r.root, 2'b01};
			if (rem2 >= trial) begin
				r.rem  = rem2 - trial;
				r.root = {r.root[RQ_W-2:0], 1'b1};
			end else begin
				r.rem  = rem2;
				r.root = {r.root[RQ_W-2:0], 1'b0};
			end
			r.rad = {r.rad[SQ_RAD_W-3:0], 2'b00};
		end
		return r;
	endfunction

	logic [SQ_STAGES-1:0] v_s;
	logic [SQ_STAGES-1:0] en;
	sq_t                  sq_s  [SQ_STAGES];
	srbp_ctl_t            ctl_s [SQ_STAGES];
	sq_t                  init;

	assign init.rem  = '0;
	assign init.root = '0;
	assign init.rad  = {1'b0, up_d2, {(2*F_BITS){1'b0}}};

	always_comb begin
		en[SQ_STAGES-1] = !v_s[SQ_STAGES-1] || dn_ready;
		for (int i = SQ_STAGES-2; i >= 0; i--)
			en[i] = !v_s[i] || en[i+1];
	end
	assign up_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= up_valid;
			for (int i = 1; i < SQ_STAGES; i++)
				if (en[i]) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_s[0]  <= sq_step(init);
			ctl_s[0] <= up_ctl;
		end
		for (int i = 1; i < SQ_STAGES; i++) begin
			if (en[i]) begin
				sq_s[i]  <= sq_step(sq_s[i-1]);
				ctl_s[i] <= ctl_s[i-1];
			end
		end
	end

	assign dn_valid = v_s[SQ_STAGES-1];
	assign dn_ctl   = ctl_s[SQ_STAGES-1];
	assign dn_rq    = sq_s[SQ_STAGES-1].root;

endmodule

// ===== src/srbp_div.sv =====
module srbp_div
	import srbp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  srbp_ctl_t       up_ctl,
	input  logic [RQ_W-1:0] up_rq,
	output logic            dn_valid,
	input  logic            dn_ready,
	output logic            dn_vres,
	output logic [7:0]      dn_alpha
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	srbp_ctl_t        ctl_s1, ctl_s2;
	logic [NUM_W-1:0] num_s1, rem_s2;
	logic             sat_s2;
	logic [3:0]       qh_s2;
	logic             vres_s3;
	logic [7:0]       alpha_s3;

	logic [NUM_W-1:0] num_c, rem_hc;
	logic [3:0]       qh_c, ql_c;
	logic             sat_c;
	logic [7:0]       alpha_c;

	assign en3      = !v_s3 || dn_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	// 255 * 256 / 256 cancels, so the quotient is diff*255 / den
	always_comb begin
		logic [RQ_W-1:0] diff;
		diff  = (up_ctl.full > up_rq) ? up_ctl.full - up_rq : '0;
		num_c = {diff, 8'b0} - {8'b0, diff};
	end

	always_comb begin
		logic [NUM_W-1:0] t;
		sat_c  = num_s1 >= {ctl_s1.den, 8'b0};
		rem_hc = num_s1;
		qh_c   = '0;
		for (int k = 3; k >= 0; k--) begin
			t = NUM_W'(ctl_s1.den) << (k + 4);
			if (rem_hc >= t) begin
				rem_hc  = rem_hc - t;
				qh_c[k] = 1'b1;
			end
		end
	end

	always_comb begin
		logic [NUM_W-1:0] t, rem;
		rem  = rem_s2;
		ql_c = '0;
		for (int k = 3; k >= 0; k--) begin
			t = NUM_W'(ctl_s2.den) << k;
			if (rem >= t) begin
				rem     = rem - t;
				ql_c[k] = 1'b1;
			end
		end
		if (ctl_s2.fix)
			alpha_c = ctl_s2.afix;
		else if (sat_s2)
			alpha_c = ALPHA_MAX;
		else
			alpha_c = {qh_s2, ql_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ctl_s1 <= up_ctl;
			num_s1 <= num_c;
		end
		if (en2) begin
			ctl_s2 <= ctl_s1;
			rem_s2 <= rem_hc;
			sat_s2 <= sat_c;
			qh_s2  <= qh_c;
		end
		if (en3) begin
			vres_s3  <= ctl_s2.vres;
			alpha_s3 <= alpha_c;
		end
	end

	assign dn_valid = v_s3;
	assign dn_vres  = vres_s3;
	assign dn_alpha = alpha_s3;

endmodule

// ===== src/soft_round_brush_pixel.sv =====
// Soft round brush preview: one canvas pixel (pixel_x, pixel_y) per request in,
// one premultiplied red pixel (valid_res, red = alpha) out, in order. The
// pipeline takes a new pixel every clock when the output is not stalled: four
// stages of offset, square and radius tests, six stages of square root at
// three root bits each, and three stages of falloff division: the numerator,
// then the high and the low four quotient bits. Backpressure stops only the
// stages that hold data, so bubbles are squeezed out. Configuration registers are
// written through their own port and take effect for pixels sent after the
// write; write them only while no pixel is in flight.
module soft_round_brush_pixel
	import srbp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	srbp_cfg_if.sink       cfg,
	srbp_pix_if.sink       pix,
	srbp_res_if.source     res
);

	srbp_cfg_t       cfg_w;
	logic            front_v, front_rdy;
	srbp_ctl_t       front_ctl;
	logic [D2_W-1:0] front_d2;
	logic            sq_v, sq_rdy;
	srbp_ctl_t       sq_ctl;
	logic [RQ_W-1:0] sq_rq;
	logic [7:0]      alpha_w;

	srbp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_w)
	);

	srbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_w),
		.up_valid (pix.valid),
		.up_ready (pix.ready),
		.pixel_x  (pix.pixel_x),
		.pixel_y  (pix.pixel_y),
		.dn_valid (front_v),
		.dn_ready (front_rdy),
		.dn_ctl   (front_ctl),
		.dn_d2    (front_d2)
	);

	srbp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (front_v),
		.up_ready (front_rdy),
		.up_ctl   (front_ctl),
		.up_d2    (front_d2),
		.dn_valid (sq_v),
		.dn_ready (sq_rdy),
		.dn_ctl   (sq_ctl),
		.dn_rq    (sq_rq)
	);

	srbp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sq_v),
		.up_ready (sq_rdy),
		.up_ctl   (sq_ctl),
		.up_rq    (sq_rq),
		.dn_valid (res.valid),
		.dn_ready (res.ready),
		.dn_vres  (res.valid_res),
		.dn_alpha (alpha_w)
	);

	assign res.alpha = alpha_w;
	assign res.red   = alpha_w;

	a_invalid_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.valid_res |-> alpha_w == 8'd0)
		else $error("alpha set on a pixel outside the canvas");

	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (cfg_w.radius == '0 || cfg_w.half == '0) |-> !res.valid_res)
		else $error("result marked valid while the brush is disabled");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_v && !front_rdy |=> front_v && $stable(front_d2))
		else $error("front stage lost a stalled request");

	a_sqrt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v && !sq_rdy |=> sq_v && $stable(sq_rq))
		else $error("root stage lost a stalled request");

endmodule
